// ===== hw/rtl/stq_pkg.sv =====
// Shared types, codes and constants for the sorted timer event queue.
package stq_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int MAX_RESULTS  = 32;
	localparam int TIME_W       = 32;
	localparam int ID_W         = 31;
	localparam int PEND_W       = 6;
	localparam int IN_TDATA_W   = 128;
	localparam int OUT_TDATA_W  = 104;

	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_DELETE = 2'd1,
		FN_RUN    = 2'd2,
		FN_REARM  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EXPIRED  = 3'd4,
		ST_NONE     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_INC,
		PTR_DEC,
		PTR_TOP,
		PTR_GAP
	} ptr_op_t;

	typedef enum logic [1:0] {
		WR_UP_RDATA,
		WR_UP_NEW,
		WR_PTR_NEW,
		WR_BACK_RDATA
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_SUB_GAP
	} cnt_op_t;

	// One stored event
	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] interval;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic    accept;
		ptr_op_t ptr_op;
		logic    gap_one;
		logic    gap_ptr;
		logic    we;
		wr_op_t  wr_op;
		cnt_op_t cnt_op;
		logic    id_adv;
		logic    emit;
		status_t res;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		func_t in_func;
		logic  in_zero;
		func_t cur_func;
		logic  full;
		logic  empty;
		logic  ins_less;
		logic  ptr_zero;
		logic  ptr_last;
		logic  ptr_lt_count;
		logic  run_due;
		logic  id_match;
		logic  emit_last;
		logic  out_free;
	} sts_t;

endpackage

// ===== hw/rtl/stq_datapath.sv =====
// Event store, index registers, deadline arithmetic and result register.
module stq_datapath #(
	parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [1:0]                       in_tuser,   // func
	input  logic [stq_pkg::IN_TDATA_W-1:0]   in_tdata,   // now_ms, delay_ms, event_id, base_ms
	input  stq_pkg::cmd_t                    cmd,
	output stq_pkg::sts_t                    sts,
	input  logic                             out_tready,
	output logic                             out_tvalid,
	output logic [stq_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_id, interval_ms, deadline_ms, pending
	output logic [2:0]                       out_tuser,  // status
	output logic                             out_tlast
);
	import stq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	entry_t mem [CAPACITY];
	entry_t rdata_s1;

	// Latched item
	func_t             func_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] delay_q;
	logic [ID_W-1:0]   eid_q;
	logic [ID_W-1:0]   ins_id_q;
	logic [TIME_W-1:0] newdl_q;

	logic [CW-1:0]   count_q, ptr_q, gap_q, ptr_d, waddr;
	logic [ID_W-1:0] next_id_q;
	logic [AW-1:0]   raddr;
	entry_t          wdata, new_entry;

	logic [TIME_W-1:0] in_now, in_delay, in_base, base_sel, dl_sum, dl_new;
	logic [ID_W-1:0]   in_eid;
	func_t             in_func;

	// Result register
	logic              out_valid_q;
	status_t           res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [TIME_W-1:0] res_iv_q;
	logic [TIME_W-1:0] res_dl_q;
	logic              res_last_q;
	logic [PEND_W-1:0] res_pend_q;

	assign in_func  = func_t'(in_tuser);
	assign in_now   = in_tdata[31:0];
	assign in_delay = in_tdata[63:32];
	assign in_eid   = in_tdata[94:64];
	assign in_base  = in_tdata[126:95];

	// Deadline: base (now if zero or add) plus delay, clamped to now
	always_comb begin
		base_sel = (in_func == FN_ADD || in_base == '0) ? in_now : in_base;
		dl_sum   = base_sel + in_delay;
		dl_new   = (dl_sum < in_now) ? in_now : dl_sum;
	end

	// Input latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= in_func;
			now_q    <= in_now;
			delay_q  <= in_delay;
			eid_q    <= in_eid;
			ins_id_q <= (in_func == FN_ADD) ? next_id_q : in_eid;
			newdl_q  <= dl_new;
		end
	end

	// Pointer next value
	always_comb begin
		case (cmd.ptr_op)
			PTR_HOLD: ptr_d = ptr_q;
			PTR_ZERO: ptr_d = '0;
			PTR_INC:  ptr_d = ptr_q + CW'(1);
			PTR_DEC:  ptr_d = ptr_q - CW'(1);
			PTR_TOP:  ptr_d = count_q - CW'(1);
			PTR_GAP:  ptr_d = gap_q;
			default:  ptr_d = ptr_q;
		endcase
	end

	assign raddr     = (ptr_d < CW'(CAPACITY)) ? ptr_d[AW-1:0] : '0;
	assign new_entry = '{deadline: newdl_q, id: ins_id_q, interval: delay_q};

	// Write port selection
	always_comb begin
		case (cmd.wr_op)
			WR_UP_RDATA: begin
				waddr = ptr_q + CW'(1);
				wdata = rdata_s1;
			end
			WR_UP_NEW: begin
				waddr = ptr_q + CW'(1);
				wdata = new_entry;
			end
			WR_PTR_NEW: begin
				waddr = ptr_q;
				wdata = new_entry;
			end
			WR_BACK_RDATA: begin
				waddr = ptr_q - gap_q;
				wdata = rdata_s1;
			end
			default: begin
				waddr = ptr_q;
				wdata = rdata_s1;
			end
		endcase
	end

	// Event memory, registered read at the next pointer
	always_ff @(posedge clk) begin
		if (cmd.we)
			mem[waddr[AW-1:0]] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			gap_q     <= '0;
			next_id_q <= ID_W'(1);
		end else begin
			ptr_q <= ptr_d;
			if (cmd.gap_one)
				gap_q <= CW'(1);
			else if (cmd.gap_ptr)
				gap_q <= ptr_q;
			case (cmd.cnt_op)
				CNT_INC:     count_q <= count_q + CW'(1);
				CNT_SUB_GAP: count_q <= count_q - gap_q;
				default:     count_q <= count_q;
			endcase
			if (cmd.id_adv && func_q == FN_ADD)
				next_id_q <= (next_id_q == ID_MAX) ? ID_W'(1) : next_id_q + ID_W'(1);
		end
	end

	// Status to controller
	always_comb begin
		sts.in_func      = in_func;
		sts.in_zero      = (in_delay == '0);
		sts.cur_func     = func_q;
		sts.full         = (count_q == CW'(CAPACITY));
		sts.empty        = (count_q == '0);
		sts.ins_less     = (newdl_q < rdata_s1.deadline);
		sts.ptr_zero     = (ptr_q == '0);
		sts.ptr_last     = ((ptr_q + CW'(1)) >= count_q);
		sts.ptr_lt_count = (ptr_q < count_q);
		sts.run_due      = (ptr_q < count_q) && (int'(ptr_q) < MAX_RESULTS) &&
			(rdata_s1.deadline <= now_q);
		sts.id_match     = (rdata_s1.id == eid_q);
		sts.emit_last    = ((ptr_q + CW'(1)) == gap_q);
		sts.out_free     = !out_valid_q || out_tready;
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_tready)
			out_valid_q <= 1'b0;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_status_q <= cmd.res;
			res_last_q   <= 1'b1;
			res_pend_q   <= PEND_W'(count_q);
			res_id_q     <= '0;
			res_iv_q     <= '0;
			res_dl_q     <= '0;
			case (cmd.res)
				ST_EXPIRED: begin
					res_id_q   <= rdata_s1.id;
					res_iv_q   <= rdata_s1.interval;
					res_dl_q   <= rdata_s1.deadline;
					res_last_q <= ((ptr_q + CW'(1)) == gap_q);
					res_pend_q <= PEND_W'(count_q - gap_q);
				end
				ST_OK: begin
					if (func_q == FN_DELETE) begin
						res_id_q <= eid_q;
					end else begin
						res_id_q <= ins_id_q;
						res_iv_q <= delay_q;
						res_dl_q <= newdl_q;
					end
				end
				ST_NOTFOUND: res_id_q <= eid_q;
				default: res_id_q <= '0;
			endcase
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tuser  = res_status_q;
	assign out_tlast  = res_last_q;
	assign out_tdata  = {3'b000, res_pend_q, res_dl_q, res_iv_q, res_id_q};

endmodule

// ===== hw/rtl/stq_ctrl.sv =====
// Sequencer for insert, delete, expiry run and compaction.
module stq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_tvalid,
	output logic          in_tready,
	input  stq_pkg::sts_t sts,
	output stq_pkg::cmd_t cmd
);
	import stq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_PUT,
		S_DEL_CMP,
		S_RUN_SCAN,
		S_RUN_EMIT,
		S_MOVE,
		S_RESP
	} state_t;

	state_t  state_q, state_d;
	status_t res_q, res_d;

	assign in_tready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_tvalid) begin
					cmd.accept = 1'b1;
					case (sts.in_func)
						FN_ADD, FN_REARM: begin
							if (sts.in_func == FN_ADD && sts.in_zero) begin
								res_d   = ST_ZERO;
								state_d = S_RESP;
							end else if (sts.full) begin
								res_d   = ST_FULL;
								state_d = S_RESP;
							end else if (sts.empty) begin
								cmd.ptr_op = PTR_ZERO;
								state_d    = S_INS_PUT;
							end else begin
								cmd.ptr_op = PTR_TOP;
								state_d    = S_INS_CMP;
							end
						end
						FN_DELETE: begin
							if (sts.empty) begin
								res_d   = ST_NOTFOUND;
								state_d = S_RESP;
							end else begin
								cmd.ptr_op = PTR_ZERO;
								state_d    = S_DEL_CMP;
							end
						end
						default: begin
							if (sts.empty) begin
								res_d   = ST_NONE;
								state_d = S_RESP;
							end else begin
								cmd.ptr_op = PTR_ZERO;
								state_d    = S_RUN_SCAN;
							end
						end
					endcase
				end
			end
			// Walk down from the top, moving later deadlines up one slot
			S_INS_CMP: begin
				cmd.we = 1'b1;
				if (sts.ins_less) begin
					cmd.wr_op = WR_UP_RDATA;
					if (sts.ptr_zero)
						state_d = S_INS_PUT;
					else
						cmd.ptr_op = PTR_DEC;
				end else begin
					cmd.wr_op  = WR_UP_NEW;
					cmd.cnt_op = CNT_INC;
					cmd.id_adv = 1'b1;
					res_d      = ST_OK;
					state_d    = S_RESP;
				end
			end
			S_INS_PUT: begin
				cmd.we     = 1'b1;
				cmd.wr_op  = WR_PTR_NEW;
				cmd.cnt_op = CNT_INC;
				cmd.id_adv = 1'b1;
				res_d      = ST_OK;
				state_d    = S_RESP;
			end
			// Search by id from the head
			S_DEL_CMP: begin
				if (sts.id_match) begin
					cmd.ptr_op  = PTR_INC;
					cmd.gap_one = 1'b1;
					res_d       = ST_OK;
					state_d     = S_MOVE;
				end else if (sts.ptr_last) begin
					res_d   = ST_NOTFOUND;
					state_d = S_RESP;
				end else begin
					cmd.ptr_op = PTR_INC;
				end
			end
			// Count due events at the head
			S_RUN_SCAN: begin
				if (sts.run_due) begin
					cmd.ptr_op = PTR_INC;
				end else if (sts.ptr_zero) begin
					res_d   = ST_NONE;
					state_d = S_RESP;
				end else begin
					cmd.gap_ptr = 1'b1;
					cmd.ptr_op  = PTR_ZERO;
					state_d     = S_RUN_EMIT;
				end
			end
			S_RUN_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.res  = ST_EXPIRED;
					if (sts.emit_last) begin
						cmd.ptr_op = PTR_GAP;
						state_d    = S_MOVE;
					end else begin
						cmd.ptr_op = PTR_INC;
					end
				end
			end
			// Close the gap left by removed entries
			S_MOVE: begin
				if (sts.ptr_lt_count) begin
					cmd.we     = 1'b1;
					cmd.wr_op  = WR_BACK_RDATA;
					cmd.ptr_op = PTR_INC;
				end else begin
					cmd.cnt_op = CNT_SUB_GAP;
					state_d    = (sts.cur_func == FN_RUN) ? S_IDLE : S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and registered result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

// ===== hw/rtl/sorted_timer_event_queue_unit.sv =====
// Top level of the sorted timer event queue.
//
// Commands enter on the s_axis channel: tuser carries the function (add,
// delete by id, run expirations, rearm), tdata the times and the id.
// Results leave on the m_axis channel: tuser carries the status, tlast
// marks the final result of a command. Add, delete and rearm give one
// result; a run gives one result per expired event (at most 32) or one
// "nothing expired" result.
// One command is worked at a time. An insert walks down from the tail,
// one stored event per cycle; a delete scans by id and compacts; a run
// scans the due events at the head, emits them and compacts. The event
// memory allows one registered read and one write per cycle.
// After reset the queue is empty and the id counter is 1; no clearing
// pass is needed. A stalled receiver holds the result register and the
// sequencer waits at its next result; no result is dropped.
module sorted_timer_event_queue_unit #(
	parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [stq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // now_ms, delay_ms, event_id, base_ms
	input  logic [1:0]                       s_axis_tuser,  // func
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [stq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // out_id, interval_ms, deadline_ms, pending
	output logic [2:0]                       m_axis_tuser,  // status
	output logic                             m_axis_tlast
);
	import stq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tuser   (s_axis_tuser),
		.in_tdata   (s_axis_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast)
	);

endmodule
